@@ hdl/pts_pkg.sv @@
`default_nettype none

package pts_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 32;
    localparam int TNUM_W     = 32;
    localparam int SPT_W      = 13;
    localparam int STK_W      = 17;
    localparam int LEN_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int DEFAULT_MAX_SAMPLES = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_TRACE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT       = 2'd1;

    localparam logic [SPT_W-1:0] SPT_RESET = 13'd4096;
    localparam logic [STK_W-1:0] STK_RESET = 17'd1;

    typedef struct packed {
        logic                       valid;
        logic                       bad;
        logic                       fin_pulse;
        logic                       last;
        logic signed [SAMPLE_W-1:0] sample;
        logic [TNUM_W-1:0]          tnum;
    } issue_t;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic              last;
        logic [TNUM_W-1:0] tnum;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/pts_acc_ram.sv @@
`default_nettype none

module pts_acc_ram #(
    parameter int DEPTH  = pts_pkg::DEFAULT_MAX_SAMPLES,
    parameter int ADDR_W = 12
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [ADDR_W-1:0]        waddr,
    input  wire logic [pts_pkg::SUM_W-1:0] wdata,
    input  wire logic                     re,
    input  wire logic [ADDR_W-1:0]        raddr,
    output logic [pts_pkg::SUM_W-1:0]     rdata
);
    import pts_pkg::*;

    logic [SUM_W-1:0] mem [0:DEPTH-1];
    logic [SUM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/pts_seq.sv @@
`default_nettype none

module pts_seq #(
    parameter int MAX_SAMPLES = pts_pkg::DEFAULT_MAX_SAMPLES,
    parameter int ADDR_W      = 12
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire logic signed [pts_pkg::SAMPLE_W-1:0] sample_real,
    input  wire logic                           pulse_bad,
    input  wire logic                           hold,
    input  wire logic                           cfg_valid,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                rd_en,
    output logic [ADDR_W-1:0]                   rd_addr,
    output pts_pkg::issue_t                     issue,
    output logic [ADDR_W-1:0]                   issue_addr,
    output logic                                clr_we,
    output logic [ADDR_W-1:0]                   clr_addr
);
    import pts_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_SAMPLES - 1);
    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_SAMPLES);

    logic [SPT_W-1:0]  spt_reg, spt_next;
    logic [STK_W-1:0]  stk_reg, stk_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [STK_W-1:0]  ps_reg, ps_next;
    logic [TNUM_W-1:0] td_reg, td_next;
    logic              clr_reg, clr_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    issue_t            issue_reg, issue_next;
    logic [ADDR_W-1:0] issue_addr_reg, issue_addr_next;

    logic              accept;
    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  pos_inc;
    logic [STK_W-1:0]  stk_eff;
    logic [STK_W:0]    ps_inc;
    logic              last;
    logic              fin_pulse;

    assign sample_stall = clr_reg | hold;
    assign accept       = sample_valid & ~sample_stall;

    always_comb
    begin
        if (spt_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (LEN_W'(spt_reg) > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        else
        begin
            len_eff = LEN_W'(spt_reg);
        end
        stk_eff   = (stk_reg == '0) ? STK_W'(1) : stk_reg;
        pos_inc   = LEN_W'(pos_reg) + LEN_W'(1);
        ps_inc    = {1'b0, ps_reg} + (STK_W + 1)'(1);
        last      = pos_inc >= len_eff;
        fin_pulse = ps_inc >= {1'b0, stk_eff};
    end

    always_comb
    begin
        spt_next        = spt_reg;
        stk_next        = stk_reg;
        pos_next        = pos_reg;
        ps_next         = ps_reg;
        td_next         = td_reg;
        clr_next        = clr_reg;
        clr_addr_next   = clr_addr_reg;
        issue_addr_next = issue_addr_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SAMPLES_PER_TRACE: spt_next = cfg_data[SPT_W-1:0];
                REG_STACK_COUNT:       stk_next = cfg_data[STK_W-1:0];
                default:               ;
            endcase
        end

        // clearing pass after reset
        if (clr_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_next = 1'b0;
            end
        end

        issue_next           = issue_reg;
        issue_next.valid     = accept;
        if (accept)
        begin
            issue_next.bad       = pulse_bad;
            issue_next.fin_pulse = fin_pulse;
            issue_next.last      = last;
            issue_next.sample    = sample_real;
            issue_next.tnum      = td_reg + TNUM_W'(1);
            issue_addr_next      = pos_reg;
            pos_next             = last ? '0 : ADDR_W'(pos_inc);
            if (!pulse_bad && last)
            begin
                if (fin_pulse)
                begin
                    ps_next = '0;
                    td_next = td_reg + TNUM_W'(1);
                end
                else
                begin
                    ps_next = ps_inc[STK_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg         <= SPT_RESET;
            stk_reg         <= STK_RESET;
            pos_reg         <= '0;
            ps_reg          <= '0;
            td_reg          <= '0;
            clr_reg         <= 1'b1;
            clr_addr_reg    <= '0;
            issue_reg       <= '0;
        end
        else
        begin
            spt_reg         <= spt_next;
            stk_reg         <= stk_next;
            pos_reg         <= pos_next;
            ps_reg          <= ps_next;
            td_reg          <= td_next;
            clr_reg         <= clr_next;
            clr_addr_reg    <= clr_addr_next;
            issue_reg       <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_addr_reg      <= issue_addr_next;
    end

    assign rd_en      = accept;
    assign rd_addr    = pos_reg;
    assign issue      = issue_reg;
    assign issue_addr = issue_addr_reg;
    assign clr_we     = clr_reg;
    assign clr_addr   = clr_addr_reg;

endmodule

`default_nettype wire

@@ hdl/pts_out_fifo.sv @@
`default_nettype none

module pts_out_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire pts_pkg::result_t push_data,
    input  wire logic          pop,
    output logic               head_valid,
    output pts_pkg::result_t   head_data,
    output logic [2:0]         count
);
    import pts_pkg::*;

    result_t     slots [0:3];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'b00, push} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = count_reg != '0;
    assign head_data  = slots[rd_ptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire

@@ hdl/pulse_trace_stacker.sv @@
`default_nettype none

// channel   direction  handshake               payload
// sample    in         sample_valid/stall      sample_real, pulse_bad
// result    out        result_valid/stall      stacked_sum, trace_last, trace_number
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// one sample per cycle while sample_stall is low; a good sample of a stack's last
// pulse yields a result via the accumulator read, add and write back, then the queue
// after reset all MAX_SAMPLES accumulator ram entries are cleared with
// sample_stall high; cfg writes are taken at any time
// a stalled result side fills a four-entry output queue, after which
// sample_stall rises

module pulse_trace_stacker #(
    parameter int MAX_SAMPLES = pts_pkg::DEFAULT_MAX_SAMPLES
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                sample_valid,
    output logic                                     sample_stall,
    input  wire logic signed [pts_pkg::SAMPLE_W-1:0] sample_real,
    input  wire logic                                pulse_bad,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic signed [pts_pkg::SUM_W-1:0]         stacked_sum,
    output logic                                     trace_last,
    output logic [pts_pkg::TNUM_W-1:0]               trace_number,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pts_pkg::*;

    localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    logic              hold;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    issue_t            s1;
    logic [ADDR_W-1:0] s1_addr;
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
    logic [SUM_W-1:0]  rd_data;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SUM_W-1:0]  ram_wdata;

    logic              wb_valid_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    logic [SUM_W-1:0]  wb_data_reg;

    logic [SUM_W-1:0]  base;
    logic [SUM_W-1:0]  sum;
    logic              s1_we;
    logic              emit;
    result_t           res;
    result_t           head;
    logic              pop;
    logic [2:0]        fifo_count;

    pts_seq #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .ADDR_W      (ADDR_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_real  (sample_real),
        .pulse_bad    (pulse_bad),
        .hold         (hold),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .issue        (s1),
        .issue_addr   (s1_addr),
        .clr_we       (clr_we),
        .clr_addr     (clr_addr)
    );

    pts_acc_ram #(
        .DEPTH  (MAX_SAMPLES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // forward the write that landed on the same edge as this read
    always_comb
    begin
        base  = (wb_valid_reg && wb_addr_reg == s1_addr) ? wb_data_reg : rd_data;
        sum   = base + {{(SUM_W - SAMPLE_W){s1.sample[SAMPLE_W-1]}}, s1.sample};
        s1_we = s1.valid & ~s1.bad;
        emit  = s1_we & s1.fin_pulse;

        if (clr_we)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_we;
            ram_waddr = s1_addr;
            ram_wdata = s1.fin_pulse ? '0 : sum;
        end

        res.sum  = sum;
        res.last = s1.last;
        res.tnum = s1.tnum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= ram_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            wb_addr_reg <= ram_waddr;
            wb_data_reg <= ram_wdata;
        end
    end

    pts_out_fifo u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (emit),
        .push_data  (res),
        .pop        (pop),
        .head_valid (result_valid),
        .head_data  (head),
        .count      (fifo_count)
    );

    assign pop          = result_valid & ~result_stall;
    assign hold         = (fifo_count + {2'b00, emit}) >= 3'd4;
    assign stacked_sum  = head.sum;
    assign trace_last   = head.last;
    assign trace_number = head.tnum;
    assign cfg_ready    = 1'b1;

endmodule

`default_nettype wire
